@@ hw/rtl/fcal_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcal_pkg: shared definitions for the fixed-capacity array list
// field widths, operation and status codes, controller-to-datapath commands
// ----------------------------------------------------------------------------
package fcal_pkg;

  // payload field widths
  localparam int MODE_W  = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 4;

  // default number of list slots
  localparam int DEF_CAPACITY = 8;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_FRONT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SORTED    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AT        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT = 3'd5;
  localparam logic [MODE_W-1:0] MODE_POP_BACK  = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_POS   = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the accepted request
    logic compare;  // run the per-slot compare and register the hit vector
    logic apply;    // shift the slots, update the count, load the result
  } fcal_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/fcal_chan_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcal channels: request and result interfaces
// valid/ready channels carrying one request or one result per transfer
// ----------------------------------------------------------------------------
interface fcal_in_if;
  import fcal_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VAL_W-1:0]  item_value;
  logic [POS_W-1:0]  position;

  modport source (output valid, output mode, output item_value, output position,
                  input ready);
  modport sink   (input valid, input mode, input item_value, input position,
                  output ready);
endinterface

interface fcal_out_if;
  import fcal_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;
  logic               is_full;
  logic               is_empty;

  modport source (output valid, output status, output entry_count, output is_full,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input entry_count, input is_full,
                  input is_empty, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fcal_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcal_ctrl: request sequencer
// walks each request through capture, compare and apply, and owns the
// result valid flag so a new request can enter while a result waits
// ----------------------------------------------------------------------------
module fcal_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fcal_pkg::fcal_cmd_t    cmd
);
  import fcal_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_COMPARE = 2'd1;
  localparam logic [1:0] S_APPLY   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.apply   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a result is never loaded over one that has not been taken
  a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (!out_valid_r || out_ready))
    else $error("result loaded while previous result pending");

  // an accepted request is compared in the next cycle
  a_accept_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.compare)
    else $error("accepted request not compared");

  // compare is always followed by the apply state
  a_compare_apply: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.compare |=> (state_r == S_APPLY))
    else $error("compare not followed by apply");

  // applying a request raises the result valid flag
  a_apply_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid)
    else $error("result not presented after apply");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/fcal_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcal_dp: slot row and result register
// one cell per slot compares against the request in parallel; a prefix mask
// then selects the slots that shift up on insert or down on removal
// ----------------------------------------------------------------------------
module fcal_dp #(
  parameter int CAPACITY = fcal_pkg::DEF_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fcal_pkg::fcal_cmd_t           cmd,
  input  wire logic [fcal_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [fcal_pkg::VAL_W-1:0]    in_item_value,
  input  wire logic [fcal_pkg::POS_W-1:0]    in_position,
  output logic      [fcal_pkg::STAT_W-1:0]   out_status,
  output logic      [fcal_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                               out_is_full,
  output logic                               out_is_empty
);
  import fcal_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // captured request
  logic [MODE_W-1:0]       mode_r;
  logic [VAL_W-1:0]        val_r;
  logic [POS_W-1:0]        pos_r;

  // slot row and count
  logic [VAL_W-1:0]        entry_r [CAPACITY];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CAPACITY-1:0]     hit_r, hit_nxt;
  logic [CAPACITY-1:0]     mask;

  // result register
  logic [STAT_W-1:0]       status_r, status_nxt;
  logic [COUNT_W-1:0]      ecount_r;
  logic                    full_out_r, empty_out_r;

  logic                    is_ins, is_full, is_empty, found, pos_bad;
  logic                    ins_ok, rem_shift, rem_ok;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      val_r  <= in_item_value;
      pos_r  <= in_position;
    end
  end

  // per-slot compare and prefix mask
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic live, less, equal, at_or_past_pos;
    localparam logic [CAPACITY-1:0] LOW_MASK = {CAPACITY{1'b1}} >> (CAPACITY - 1 - i);

    assign live           = CNT_W'(i) < count_r;
    assign less           = $signed(entry_r[i]) < $signed(val_r);
    assign equal          = entry_r[i] == val_r;
    assign at_or_past_pos = CMP_W'(i) >= CMP_W'(pos_r);

    always_comb begin
      case (mode_r)
        MODE_FRONT, MODE_POP_FRONT: hit_nxt[i] = 1'b1;
        MODE_APPEND:                hit_nxt[i] = !live;
        MODE_SORTED:                hit_nxt[i] = !live || !less;
        MODE_AT:                    hit_nxt[i] = at_or_past_pos;
        MODE_REMOVE:                hit_nxt[i] = live && equal;
        default:                    hit_nxt[i] = 1'b0;
      endcase
    end

    // slot i lies at or past the first hit
    assign mask[i] = |(hit_r & LOW_MASK);

    // shift up on insert, down on removal
    always_ff @(posedge clk) begin
      if (cmd.apply && ins_ok) begin
        if (i > 0 && mask[(i > 0) ? i - 1 : 0]) begin
          entry_r[i] <= entry_r[(i > 0) ? i - 1 : 0];
        end else if (mask[i]) begin
          entry_r[i] <= val_r;
        end
      end else if (cmd.apply && rem_shift) begin
        if (i < CAPACITY - 1 && mask[i]) begin
          entry_r[i] <= entry_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      hit_r <= hit_nxt;
    end
  end

  // operation outcome
  assign is_ins    = mode_r inside {MODE_FRONT, MODE_APPEND, MODE_SORTED, MODE_AT};
  assign is_full   = count_r == CNT_W'(CAPACITY);
  assign is_empty  = count_r == '0;
  assign found     = |hit_r;
  assign pos_bad   = CMP_W'(pos_r) > CMP_W'(count_r);
  assign ins_ok    = is_ins && !is_full && !((mode_r == MODE_AT) && pos_bad);
  assign rem_shift = !is_empty &&
                     (((mode_r == MODE_REMOVE) && found) || (mode_r == MODE_POP_FRONT));
  assign rem_ok    = rem_shift || ((mode_r == MODE_POP_BACK) && !is_empty);

  always_comb begin
    status_nxt = STAT_OK;
    if (is_ins) begin
      if (is_full) begin
        status_nxt = STAT_FULL;
      end else if ((mode_r == MODE_AT) && pos_bad) begin
        status_nxt = STAT_BAD_POS;
      end
    end else if (mode_r inside {MODE_REMOVE, MODE_POP_FRONT, MODE_POP_BACK}) begin
      if (is_empty) begin
        status_nxt = STAT_EMPTY;
      end else if ((mode_r == MODE_REMOVE) && !found) begin
        status_nxt = STAT_NOT_FOUND;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_r    <= status_nxt;
      ecount_r    <= COUNT_W'(count_nxt);
      full_out_r  <= count_nxt == CNT_W'(CAPACITY);
      empty_out_r <= count_nxt == '0;
    end
  end

  assign out_status      = status_r;
  assign out_entry_count = ecount_r;
  assign out_is_full     = full_out_r;
  assign out_is_empty    = empty_out_r;

endmodule
`default_nettype wire

@@ hw/rtl/fixed_capacity_array_list.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_capacity_array_list: packed list of signed 32-bit values
// Each request passes through three steps: it is accepted, then every slot
// compares against the request in parallel, then the slot row shifts and the
// result register loads. The result is registered, so the next request is
// accepted while a result still waits; the apply step holds only if that
// earlier result has not been taken by then. Slot contents are not cleared at
// reset; only the count is.
// ----------------------------------------------------------------------------
module fixed_capacity_array_list #(
  parameter int CAPACITY = fcal_pkg::DEF_CAPACITY
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fcal_in_if.sink    in_ch,
  fcal_out_if.source out_ch
);
  import fcal_pkg::*;

  fcal_cmd_t cmd;

  // sequencer
  fcal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // slot row and result register
  fcal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_ch.mode),
    .in_item_value   (in_ch.item_value),
    .in_position     (in_ch.position),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count),
    .out_is_full     (out_ch.is_full),
    .out_is_empty    (out_ch.is_empty)
  );

endmodule
`default_nettype wire

@@ bench/fcal_list_scoreboard.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcal_list_scoreboard: passive checker for the fixed-capacity array list
// Watches the request and result channels. Each request transfer updates a
// private copy of the list and queues the result it should produce. Each
// result transfer is compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module fcal_list_scoreboard #(
  parameter int CAPACITY = fcal_pkg::DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst_n,
  fcal_in_if   in_ch,
  fcal_out_if  out_ch,
  output int   fail_count,
  output int   pending_count
);
  import fcal_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
    logic               is_full;
    logic               is_empty;
  } list_result_t;

  // shadow copy of the list contents and length
  logic signed [VAL_W-1:0] list_vals [CAPACITY];
  int                      list_len;

  list_result_t expected_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    list_len      = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 50) begin
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  // drop the entry at index at and close the gap
  function automatic void close_gap(input int at);
    for (int i = at; i + 1 < list_len; i++) begin
      list_vals[i] = list_vals[i + 1];
    end
    list_len--;
  endfunction

  // apply one request to the shadow list and return its result
  function automatic list_result_t predict_request(input logic [MODE_W-1:0] mode,
                                                   input logic signed [VAL_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
    list_result_t res;
    int           slot;
    res        = '0;
    res.status = STAT_OK;
    slot       = 0;
    case (mode)
      MODE_FRONT, MODE_APPEND, MODE_SORTED, MODE_AT: begin
        if (list_len >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          case (mode)
            MODE_FRONT:  slot = 0;
            MODE_APPEND: slot = list_len;
            MODE_SORTED: begin
              // new value lands ahead of any equal entries
              while (slot < list_len && list_vals[slot] < val) slot++;
            end
            default:     slot = int'(pos);
          endcase
          if (slot > list_len) begin
            res.status = STAT_BAD_POS;
          end else begin
            for (int i = list_len; i > slot; i--) begin
              list_vals[i] = list_vals[i - 1];
            end
            list_vals[slot] = val;
            list_len++;
          end
        end
      end
      MODE_REMOVE: begin
        if (list_len == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          while (slot < list_len && list_vals[slot] != val) slot++;
          if (slot == list_len) res.status = STAT_NOT_FOUND;
          else close_gap(slot);
        end
      end
      MODE_POP_FRONT: begin
        if (list_len == 0) res.status = STAT_EMPTY;
        else close_gap(0);
      end
      MODE_POP_BACK: begin
        if (list_len == 0) res.status = STAT_EMPTY;
        else list_len--;
      end
      default: ;
    endcase
    res.entry_count = COUNT_W'(list_len);
    res.is_full     = (list_len == CAPACITY);
    res.is_empty    = (list_len == 0);
    return res;
  endfunction

  // result side first, so a request in the same cycle cannot satisfy it
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_ch.status), -1);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", int'(out_ch.status), int'(want.status));
          if (out_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", int'(out_ch.entry_count),
                            int'(want.entry_count));
          if (out_ch.is_full !== want.is_full)
            report_mismatch("is_full", int'(out_ch.is_full), int'(want.is_full));
          if (out_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", int'(out_ch.is_empty), int'(want.is_empty));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_request(in_ch.mode, in_ch.item_value,
                                                   in_ch.position));
      end
      pending_count <= expected_results.size();
    end
  end

endmodule

@@ bench/tb_fixed_capacity_array_list.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_capacity_array_list: testbench for the fixed-capacity array list
// Directed requests walk through empty, full, bad position, missing value and
// sorted ordering cases, then random request streams alternate between
// filling and draining the list. Requests arrive in bursts, the result side
// stalls on its own pattern and once holds off long enough to back up input.
// ----------------------------------------------------------------------------
module tb_fixed_capacity_array_list;
  import fcal_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1675;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AFTER   = 200;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   items_sent = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  fcal_in_if  in_ch ();
  fcal_out_if out_ch ();

  fixed_capacity_array_list #(.CAPACITY(DEF_CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fcal_list_scoreboard #(.CAPACITY(DEF_CAPACITY)) u_scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // offer one request, opening a gap between bursts, and wait for its transfer
  task automatic send_req(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.item_value <= val;
    in_ch.position   <= pos;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  // small pool of repeated values so removals find matches
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return VAL_W'($urandom_range(0, 6));
      6:       return VAL_W'(0 - $urandom_range(1, 6));
      default: return $urandom();
    endcase
  endfunction

  // mostly inserts while growing, mostly removals while draining
  function automatic logic [MODE_W-1:0] pick_mode(input bit grow);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return MODE_UNUSED;
    if (grow ? (roll < 65) : (roll >= 65)) begin
      case ($urandom_range(0, 3))
        0:       return MODE_FRONT;
        1:       return MODE_APPEND;
        2:       return MODE_SORTED;
        default: return MODE_AT;
      endcase
    end
    case ($urandom_range(0, 2))
      0:       return MODE_REMOVE;
      1:       return MODE_POP_FRONT;
      default: return MODE_POP_BACK;
    endcase
  endfunction

  // result-side stall pattern, with one long hold-off
  initial begin
    int  seg;
    int  len;
    bit  hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      seg = $urandom_range(0, 2);
      len = $urandom_range(5, 60);
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        @(posedge clk);
        out_ch.ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        for (int i = 0; i < len; i++) begin
          @(posedge clk);
          case (seg)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL fixed_capacity_array_list");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    bit grow;
    int phase_left;
    logic [POS_W-1:0] pos;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_FRONT;
    in_ch.item_value <= '0;
    in_ch.position   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // removals from an empty list, unused mode, bad position when empty
    send_req(MODE_POP_BACK, 32'd0, 4'd0);
    send_req(MODE_POP_FRONT, 32'd0, 4'd0);
    send_req(MODE_REMOVE, 32'd0, 4'd0);
    send_req(MODE_UNUSED, 32'hFFFF_FFFF, 4'hF);
    send_req(MODE_AT, 32'd1, 4'd1);
    // build up with every insert mode and the value extremes
    send_req(MODE_AT, 32'd10, 4'd0);
    send_req(MODE_FRONT, 32'h7FFF_FFFF, 4'd0);
    send_req(MODE_APPEND, 32'h8000_0000, 4'd0);
    send_req(MODE_SORTED, 32'd10, 4'd0);
    send_req(MODE_SORTED, 32'hFFFF_FFFF, 4'd0);
    send_req(MODE_AT, 32'd3, 4'hF);
    send_req(MODE_AT, 32'd7, 4'd5);
    // missing value, then first of two equal entries
    send_req(MODE_REMOVE, 32'd12345, 4'd0);
    send_req(MODE_REMOVE, 32'd10, 4'd0);
    send_req(MODE_SORTED, 32'd3, 4'd0);
    send_req(MODE_SORTED, 32'd10, 4'd0);
    send_req(MODE_APPEND, 32'hAAAA_5555, 4'd0);
    // full list refuses every insert, bad position included
    send_req(MODE_FRONT, 32'd1, 4'd0);
    send_req(MODE_APPEND, 32'd1, 4'd0);
    send_req(MODE_SORTED, 32'd1, 4'd0);
    send_req(MODE_AT, 32'd1, 4'hF);
    send_req(MODE_UNUSED, 32'd0, 4'd0);
    send_req(MODE_POP_FRONT, 32'd0, 4'd0);
    send_req(MODE_POP_BACK, 32'd0, 4'd0);
    send_req(MODE_REMOVE, 32'h8000_0000, 4'd0);

    // random streams alternating between filling and draining
    grow       = 1'b1;
    phase_left = $urandom_range(10, 40);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        grow       = !grow;
        phase_left = $urandom_range(10, 40);
      end
      phase_left--;
      if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, DEF_CAPACITY));
      else pos = POS_W'($urandom_range(0, 15));
      send_req(pick_mode(grow), pick_value(), pos);
    end
    in_ch.valid <= 1'b0;

    // let the pending count see the last transfer, drain, then settle
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS fixed_capacity_array_list");
    end else begin
      $display("FAIL fixed_capacity_array_list");
    end
    $finish;
  end

endmodule
